/* rtl/tpc_pkg.sv */
// Shared types and constants for the thermal pixel colorizer.
package tpc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COLOR_W  = 16;
  localparam int INDEX_W  = 8;
  localparam int NUM_W    = SAMPLE_W + INDEX_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [INDEX_W-1:0] TOP_INDEX    = 8'd255;
  localparam logic [INDEX_W-1:0] BOTTOM_INDEX = 8'd0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 1'b1;

  localparam logic [SAMPLE_W-1:0] MIN_LEVEL_RESET = 16'h0000;
  localparam logic [SAMPLE_W-1:0] MAX_LEVEL_RESET = 16'hFFFF;

  // Input item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_entry;    // write a palette entry from the input transaction
    logic capture;     // latch the sample of a pixel transaction
    logic prep;        // compare against the window, form offset and span
    logic load;        // scale the offset by 255 and seed the divider
    logic div_step;    // one restoring division step
    logic lookup;      // read the palette at the final index
  } tpc_cmd_t;

endpackage

/* rtl/tpc_stream_if.sv */
// Valid/ready channels for palette and pixel transactions and for result transactions.
interface tpc_in_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [tpc_pkg::SAMPLE_W-1:0] sample_value;
  logic [tpc_pkg::INDEX_W-1:0]  entry_index;
  logic [tpc_pkg::COLOR_W-1:0]  entry_color;

  modport source (output valid, mode, sample_value, entry_index, entry_color, input ready);
  modport sink   (input valid, mode, sample_value, entry_index, entry_color, output ready);
endinterface

interface tpc_out_if;
  logic                        valid;
  logic                        ready;
  logic [tpc_pkg::COLOR_W-1:0] pixel_color;
  logic                        last_copy;
  logic                        clamped;

  modport source (output valid, pixel_color, last_copy, clamped, input ready);
  modport sink   (input valid, pixel_color, last_copy, clamped, output ready);
endinterface

/* rtl/thermal_pixel_colorizer.sv */
// Top level of the thermal pixel colorizer: controller, datapath and channel wiring.
//
// Input channel pix_in carries two kinds of transaction. Mode 0 writes
// entry_color into palette entry entry_index and produces no result. Mode 1
// maps sample_value through the window [min_level, max_level] to a palette
// index 0..255 and sends the palette color REPEAT times on pix_out, with
// last_copy on the final copy and clamped on every copy when the sample lay
// outside the window or the window was empty.
// The window registers are written through cfg_we / cfg_index / cfg_data;
// the user must write them only while the block is idle, which the block
// itself does not enforce. Every palette entry that is looked up must
// have been loaded after reset.
// After a palette write the block stays idle and can accept the next
// transaction in the following cycle. A pixel transaction passes through
// the window check, scaling, an 8-step radix-2 divider and a registered
// palette read before its first copy is presented. The next transaction
// is taken only after the last copy has been accepted.
// When the receiver stalls, the current copy is held and no input is taken.
// Reset returns to idle, min_level to 0 and max_level to 65535; palette
// contents are left as they were.
module thermal_pixel_colorizer #(
  parameter int REPEAT = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpc_pkg::SAMPLE_W-1:0]  cfg_data,
  tpc_in_if.sink                        pix_in,
  tpc_out_if.source                     pix_out
);
  import tpc_pkg::*;

  tpc_cmd_t cmd;

  tpc_ctrl #(
    .REPEAT(REPEAT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_in.valid),
    .in_mode  (pix_in.mode),
    .in_ready (pix_in.ready),
    .out_valid(pix_out.valid),
    .out_last (pix_out.last_copy),
    .out_ready(pix_out.ready),
    .cmd      (cmd)
  );

  tpc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_value(pix_in.sample_value),
    .entry_index (pix_in.entry_index),
    .entry_color (pix_in.entry_color),
    .pixel_color (pix_out.pixel_color),
    .clamped     (pix_out.clamped)
  );

`ifndef ASSERT_OFF
  // No input is taken while a copy is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> !pix_in.ready)
    else $error("input ready while a result is pending");

  // A pixel transaction cannot produce a result in the next cycle
  a_pixel_latency: assert property (@(posedge clk) disable iff (rst)
    (pix_in.valid && pix_in.ready && (pix_in.mode == MODE_PIXEL)) |=> !pix_out.valid)
    else $error("result too early after pixel transaction");

  // A palette write leaves the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    (pix_in.valid && pix_in.ready && (pix_in.mode == MODE_LOAD)) |=> pix_in.ready)
    else $error("not ready after palette write");

  // Taking the last copy returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && pix_out.ready && pix_out.last_copy) |=> (pix_in.ready && !pix_out.valid))
    else $error("not idle after last copy");
`endif

endmodule

/* rtl/tpc_ctrl.sv */
// Controller state machine: sequences window check, division, lookup and output copies.
module tpc_ctrl #(
  parameter int REPEAT = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_mode,
  output logic               in_ready,
  output logic               out_valid,
  output logic               out_last,
  input  logic               out_ready,
  output tpc_pkg::tpc_cmd_t  cmd
);
  import tpc_pkg::*;

  localparam int COPY_W = (REPEAT > 1) ? $clog2(REPEAT) : 1;
  localparam logic [COPY_W-1:0] LAST_COPY = COPY_W'(REPEAT - 1);
  localparam logic [2:0] LAST_STEP = 3'(INDEX_W - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_LOAD, S_DIV, S_READ, S_EMIT
  } state_t;

  state_t            state;
  logic [2:0]        step;
  logic [COPY_W-1:0] copy;
  logic              accept;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = (state == S_EMIT);
  assign out_last  = (copy == LAST_COPY);

  // Decode datapath commands from the state
  always_comb begin
    cmd          = '0;
    cmd.wr_entry = accept && (in_mode == MODE_LOAD);
    cmd.capture  = accept && (in_mode == MODE_PIXEL);
    cmd.prep     = (state == S_PREP);
    cmd.load     = (state == S_LOAD);
    cmd.div_step = (state == S_DIV);
    cmd.lookup   = (state == S_READ);
  end

  // Advance state, division step count and copy count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      copy  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (in_mode == MODE_PIXEL)) state <= S_PREP;
        end
        S_PREP: state <= S_LOAD;
        S_LOAD: begin
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          step <= step + 3'd1;
          if (step == LAST_STEP) state <= S_READ;
        end
        S_READ: begin
          copy  <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_ready) begin
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              copy <= copy + COPY_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/tpc_datapath.sv */
// Datapath: window registers, radix-2 index divider and palette memory.
module tpc_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  tpc_pkg::tpc_cmd_t            cmd,
  input  logic                         cfg_we,
  input  logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpc_pkg::SAMPLE_W-1:0] cfg_data,
  input  logic [tpc_pkg::SAMPLE_W-1:0] sample_value,
  input  logic [tpc_pkg::INDEX_W-1:0]  entry_index,
  input  logic [tpc_pkg::COLOR_W-1:0]  entry_color,
  output logic [tpc_pkg::COLOR_W-1:0]  pixel_color,
  output logic                         clamped
);
  import tpc_pkg::*;

  logic [SAMPLE_W-1:0] min_level;
  logic [SAMPLE_W-1:0] max_level;
  logic [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0] offset;
  logic [SAMPLE_W-1:0] span;
  logic                sat_top;
  logic [SAMPLE_W-1:0] rem;
  logic [INDEX_W-1:0]  quo;
  logic [COLOR_W-1:0]  palette [256];

  logic [NUM_W-1:0]    scaled;
  logic [SAMPLE_W:0]   trial;
  logic                fits;
  logic [INDEX_W-1:0]  rd_addr;

  // Hold the window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_level <= MIN_LEVEL_RESET;
      max_level <= MAX_LEVEL_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MIN_LEVEL) min_level <= cfg_data;
      if (cfg_index == CFG_MAX_LEVEL) max_level <= cfg_data;
    end
  end

  // Scale by 255 as a shift and subtract; one restoring step compares and subtracts
  assign scaled  = {offset, 8'd0} - {8'd0, offset};
  assign trial   = {rem, quo[INDEX_W-1]};
  assign fits    = (trial >= {1'b0, span});
  assign rd_addr = clamped ? (sat_top ? TOP_INDEX : BOTTOM_INDEX) : quo;

  // Window check, division and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) sample <= sample_value;
    if (cmd.prep) begin
      offset  <= sample - min_level;
      span    <= max_level - min_level;
      clamped <= (max_level <= min_level) || (sample < min_level) || (sample > max_level);
      sat_top <= (max_level > min_level) && (sample > max_level);
    end
    if (cmd.load) begin
      rem <= scaled[NUM_W-1:INDEX_W];
      quo <= scaled[INDEX_W-1:0];
    end
    if (cmd.div_step) begin
      rem <= fits ? SAMPLE_W'(trial - {1'b0, span}) : trial[SAMPLE_W-1:0];
      quo <= {quo[INDEX_W-2:0], fits};
    end
  end

  // Palette memory: write on a load transaction, registered read for lookup
  always_ff @(posedge clk) begin
    if (cmd.wr_entry) palette[entry_index] <= entry_color;
    if (cmd.lookup) pixel_color <= palette[rd_addr];
  end

endmodule
